// ----- rtl/route_split_time_windows_defines.svh -----
// assertion macros for the route splitter
`ifndef ROUTE_SPLIT_TIME_WINDOWS_DEFINES_SVH
`define ROUTE_SPLIT_TIME_WINDOWS_DEFINES_SVH

`ifndef SYNTHESIS
`define RSW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RSW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSW_ASSERT_IMP(lbl, ante, cons, msg)
`define RSW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/rsw_pkg.sv -----
package rsw_pkg;

    localparam int DEF_MAX_SEQUENCE = 64;
    localparam int DEF_NUM_TASKS    = 256;
    localparam int DEF_NUM_NODES    = 256;

    localparam int          COST_W   = 24;
    localparam logic [23:0] COST_MAX = 24'hFFFFFF;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    localparam logic [1:0] REQ_LOAD_TASK   = 2'd0;
    localparam logic [1:0] REQ_LOAD_MATRIX = 2'd1;
    localparam logic [1:0] REQ_APPEND      = 2'd2;
    localparam logic [1:0] REQ_RUN         = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  index;
        logic [7:0]  to_node;
        logic [7:0]  start_node;
        logic [7:0]  end_node;
        logic [15:0] demand;
        logic [15:0] service_cost;
        logic [15:0] service_time;
        logic [15:0] window_open;
        logic [15:0] window_close;
        logic [15:0] travel_cost;
        logic [15:0] travel_time;
    } t_req;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [5:0]  route_number;
        logic        route_end;
        logic        last;
        logic        infeasible;
        logic [23:0] total_cost;
    } t_res;

    typedef struct packed {
        logic        ok;
        logic        improve;
        logic [23:0] cand;
        logic [16:0] dep;
    } t_eval;

endpackage

// ----- rtl/rsw_req_if.sv -----
interface rsw_req_if;
    import rsw_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rsw_res_if.sv -----
interface rsw_res_if;
    import rsw_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rsw_ram.sv -----
module rsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/rsw_eval.sv -----
module rsw_eval (
    input  logic [15:0]          i_cap,
    input  logic [22:0]          i_load,
    input  logic [23:0]          i_path,
    input  logic [17:0]          i_arr,
    input  logic [23:0]          i_best_prev,
    input  logic [23:0]          i_best_cur,
    input  logic                 i_reached_cur,
    input  logic [15:0]          i_depot_cost,
    input  logic [15:0]          i_open,
    input  logic [15:0]          i_close,
    input  logic [15:0]          i_stime,
    output rsw_pkg::t_eval       o_eval
);
    import rsw_pkg::*;

    logic [25:0] sum;
    logic [23:0] cand;
    logic        ok;
    logic [17:0] start;
    logic [18:0] dep;

    always_comb begin
        sum   = {2'b0, i_best_prev} + {2'b0, i_path} + {10'b0, i_depot_cost};
        cand  = (sum > {2'b0, COST_MAX}) ? COST_MAX : sum[23:0];
        ok    = (i_load <= {7'b0, i_cap}) && (i_arr <= {2'b0, i_close});
        start = (i_arr > {2'b0, i_open}) ? i_arr : {2'b0, i_open};
        dep   = {1'b0, start} + {3'b0, i_stime};
        o_eval.ok      = ok;
        o_eval.improve = ok && (!i_reached_cur || (cand < i_best_cur));
        o_eval.cand    = cand;
        o_eval.dep     = dep[16:0];
    end
endmodule

// ----- rtl/route_split_time_windows.sv -----
// load items: accepted back to back while idle
// run: init of the best-cost table, then per start position a best-cost read and per inner
// extension step reads of sequence, task, two matrix entries and best cost; then a read of the
// final entry, then results and route backtracks; results wait while the sink stalls; an empty
// run gives one result; synchronous active-low reset clears control, capacity to 65535 and
// sequence count; memories keep their contents
module route_split_time_windows #(
    parameter int MAX_SEQUENCE = rsw_pkg::DEF_MAX_SEQUENCE,
    parameter int NUM_TASKS    = rsw_pkg::DEF_NUM_TASKS,
    parameter int NUM_NODES    = rsw_pkg::DEF_NUM_NODES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    rsw_req_if.sink       i_req,
    rsw_res_if.source     o_res
);
    import rsw_pkg::*;
    `include "route_split_time_windows_defines.svh"

    localparam int POS_W     = $clog2(MAX_SEQUENCE + 1);
    localparam int SEQ_AW    = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
    localparam int TASK_AW   = $clog2(NUM_TASKS);
    localparam int NODE_W    = $clog2(NUM_NODES);
    localparam int MAT_AW    = 2 * NODE_W;
    localparam int MAT_DEPTH = 1 << MAT_AW;
    localparam int DP_W      = 1 + COST_W + POS_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_ISTART = 4'd2;
    localparam logic [3:0] ST_IWAIT  = 4'd3;
    localparam logic [3:0] ST_SEQ    = 4'd4;
    localparam logic [3:0] ST_TASK   = 4'd5;
    localparam logic [3:0] ST_M1     = 4'd6;
    localparam logic [3:0] ST_M2     = 4'd7;
    localparam logic [3:0] ST_CALC   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;
    localparam logic [3:0] ST_FINW   = 4'd10;
    localparam logic [3:0] ST_BT     = 4'd11;
    localparam logic [3:0] ST_BTW    = 4'd12;
    localparam logic [3:0] ST_ERD    = 4'd13;
    localparam logic [3:0] ST_EWR    = 4'd14;
    localparam logic [3:0] ST_EMPTY  = 4'd15;

    logic [3:0]         r_state;
    logic [15:0]        r_cap;
    logic [POS_W-1:0]   r_count, r_n, r_i, r_j, r_p, r_k, r_cur;
    logic [5:0]         r_rn;
    logic [TASK_AW-1:0] r_v;
    logic [NODE_W-1:0]  r_depot, r_tail0, r_tail_u;
    logic [23:0]        r_best_prev, r_best_cur, r_path, r_total;
    logic               r_reached_cur, r_inf;
    logic [22:0]        r_load;
    logic [17:0]        r_arr;
    logic [16:0]        r_dep;
    logic               r_out_valid;
    t_res               r_out;

    logic               req_acc, out_free, out_load;
    t_req               rq;
    logic               tl_we, mat_we, seq_we, dp_we;
    logic [TASK_AW-1:0] task_waddr, task_raddr;
    logic [MAT_AW-1:0]  mat_waddr, mat_raddr;
    logic [SEQ_AW-1:0]  seq_waddr, seq_raddr;
    logic [POS_W-1:0]   dp_waddr, dp_raddr, pos_m1, pos_j1, pos_k1, pos_i1;
    logic [DP_W-1:0]    dp_wdata;
    logic [47:0]        tl_q, tt_q;
    logic [31:0]        mat_q;
    logic [7:0]         seq_q;
    logic [DP_W-1:0]    dp_q;
    logic               dp_q_reached;
    logic [23:0]        dp_q_cost;
    logic [POS_W-1:0]   dp_q_pred;
    logic [POS_W-1:0]   pred_fix;
    logic [NODE_W-1:0]  tt_head, tt_tail;
    logic [23:0]        path_nx;
    logic [17:0]        arr_nx;
    t_eval              ev;

    assign rq           = i_req.data;
    assign i_req.ready  = (r_state == ST_IDLE);
    assign req_acc      = i_req.valid && i_req.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;
    assign out_free     = !r_out_valid || o_res.ready;
    assign out_load     = out_free && ((r_state == ST_EWR) || (r_state == ST_EMPTY));

    assign tt_head      = tt_q[40 +: NODE_W];
    assign tt_tail      = tt_q[32 +: NODE_W];
    assign dp_q_reached = dp_q[DP_W-1];
    assign dp_q_cost    = dp_q[POS_W +: COST_W];
    assign dp_q_pred    = dp_q[POS_W-1:0];
    assign pred_fix     = (dp_q_pred >= r_cur) ? '0 : dp_q_pred;
    assign pos_j1       = r_j - 1'b1;
    assign pos_k1       = r_k - 1'b1;
    assign pos_i1       = r_i - 1'b1;
    assign pos_m1       = ((r_state == ST_ERD) || (r_state == ST_EWR)) ? pos_k1 : pos_j1;

    assign path_nx = r_path + {8'b0, mat_q[31:16]} + {8'b0, tl_q[31:16]};
    assign arr_nx  = {1'b0, r_dep} + {2'b0, mat_q[15:0]};

    always_comb begin
        tl_we      = req_acc && (rq.req_type == REQ_LOAD_TASK)
                     && ({1'b0, rq.index} < 9'(NUM_TASKS))
                     && ({1'b0, rq.start_node} < 9'(NUM_NODES))
                     && ({1'b0, rq.end_node} < 9'(NUM_NODES));
        mat_we     = req_acc && (rq.req_type == REQ_LOAD_MATRIX)
                     && ({1'b0, rq.index} < 9'(NUM_NODES))
                     && ({1'b0, rq.to_node} < 9'(NUM_NODES));
        seq_we     = req_acc && (rq.req_type == REQ_APPEND)
                     && ({1'b0, rq.index} < 9'(NUM_TASKS))
                     && (r_count < POS_W'(MAX_SEQUENCE));
        task_waddr = rq.index[TASK_AW-1:0];
        mat_waddr  = {rq.index[NODE_W-1:0], rq.to_node[NODE_W-1:0]};
        seq_waddr  = r_count[SEQ_AW-1:0];
        seq_raddr  = pos_m1[SEQ_AW-1:0];
        case (r_state)
            ST_TASK:                 task_raddr = seq_q[TASK_AW-1:0];
            ST_M1, ST_M2, ST_CALC:   task_raddr = r_v;
            default:                 task_raddr = '0;
        endcase
        mat_raddr = (r_state == ST_M2) ? {tt_tail, r_depot} : {r_tail_u, tt_head};
        case (r_state)
            ST_ISTART: dp_raddr = pos_i1;
            ST_FIN:    dp_raddr = r_n;
            ST_BT:     dp_raddr = r_cur;
            default:   dp_raddr = r_j;
        endcase
        dp_we    = (r_state == ST_INIT) || ((r_state == ST_CALC) && ev.improve);
        dp_waddr = (r_state == ST_INIT) ? r_p : r_j;
        if (r_state == ST_INIT) begin
            dp_wdata = (r_p == '0) ? {1'b1, 24'd0, {POS_W{1'b0}}}
                                   : {1'b0, COST_MAX, {POS_W{1'b0}}};
        end else begin
            dp_wdata = {1'b1, ev.cand, pos_i1};
        end
    end

    rsw_ram #(.WIDTH(48), .DEPTH(NUM_TASKS)) u_task_load (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(task_waddr),
        .i_wdata({rq.demand, rq.service_cost, rq.service_time}),
        .i_raddr(task_raddr), .o_rdata(tl_q)
    );

    rsw_ram #(.WIDTH(48), .DEPTH(NUM_TASKS)) u_task_time (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(task_waddr),
        .i_wdata({rq.start_node, rq.end_node, rq.window_open, rq.window_close}),
        .i_raddr(task_raddr), .o_rdata(tt_q)
    );

    rsw_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_matrix (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_waddr),
        .i_wdata({rq.travel_cost, rq.travel_time}),
        .i_raddr(mat_raddr), .o_rdata(mat_q)
    );

    rsw_ram #(.WIDTH(8), .DEPTH(MAX_SEQUENCE)) u_sequence (
        .i_clk(i_clk), .i_we(seq_we), .i_waddr(seq_waddr), .i_wdata(rq.index),
        .i_raddr(seq_raddr), .o_rdata(seq_q)
    );

    rsw_ram #(.WIDTH(DP_W), .DEPTH(MAX_SEQUENCE + 1)) u_best (
        .i_clk(i_clk), .i_we(dp_we), .i_waddr(dp_waddr), .i_wdata(dp_wdata),
        .i_raddr(dp_raddr), .o_rdata(dp_q)
    );

    rsw_eval u_eval (
        .i_cap(r_cap), .i_load(r_load), .i_path(r_path), .i_arr(r_arr),
        .i_best_prev(r_best_prev), .i_best_cur(r_best_cur),
        .i_reached_cur(r_reached_cur), .i_depot_cost(mat_q[31:16]),
        .i_open(tt_q[31:16]), .i_close(tt_q[15:0]), .i_stime(tl_q[15:0]),
        .o_eval(ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (seq_we) begin
                r_count <= r_count + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (req_acc && (rq.req_type == REQ_RUN)) begin
                        r_n   <= r_count;
                        r_p   <= '0;
                        r_inf <= 1'b0;
                        r_state <= (r_count == '0) ? ST_EMPTY : ST_INIT;
                    end
                end
                ST_INIT: begin
                    r_depot <= tt_head;
                    r_tail0 <= tt_tail;
                    r_p     <= r_p + 1'b1;
                    if (r_p == r_n) begin
                        r_i     <= POS_W'(1);
                        r_state <= ST_ISTART;
                    end
                end
                ST_ISTART: r_state <= ST_IWAIT;
                ST_IWAIT: begin
                    if (!dp_q_reached) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= (r_i == r_n) ? ST_FIN : ST_ISTART;
                    end else begin
                        r_best_prev <= dp_q_cost;
                        r_j      <= r_i;
                        r_load   <= '0;
                        r_path   <= '0;
                        r_dep    <= '0;
                        r_tail_u <= r_tail0;
                        r_state  <= ST_SEQ;
                    end
                end
                ST_SEQ: r_state <= ST_TASK;
                ST_TASK: begin
                    r_v     <= seq_q[TASK_AW-1:0];
                    r_state <= ST_M1;
                end
                ST_M1: r_state <= ST_M2;
                ST_M2: begin
                    r_best_cur    <= dp_q_cost;
                    r_reached_cur <= dp_q_reached;
                    r_load  <= r_load + {7'b0, tl_q[47:32]};
                    r_path  <= path_nx;
                    r_arr   <= arr_nx;
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (!ev.ok || (r_j == r_n)) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= (r_i == r_n) ? ST_FIN : ST_ISTART;
                    end else begin
                        r_j      <= r_j + 1'b1;
                        r_dep    <= ev.dep;
                        r_tail_u <= tt_tail;
                        r_state  <= ST_SEQ;
                    end
                end
                ST_FIN: r_state <= ST_FINW;
                ST_FINW: begin
                    r_cur <= r_n;
                    r_rn  <= '0;
                    if (!dp_q_reached) begin
                        r_inf   <= 1'b1;
                        r_total <= COST_MAX;
                        r_p     <= '0;
                        r_k     <= POS_W'(1);
                        r_state <= ST_ERD;
                    end else begin
                        r_total <= dp_q_cost;
                        r_state <= ST_BT;
                    end
                end
                ST_BT: r_state <= ST_BTW;
                ST_BTW: begin
                    r_p     <= pred_fix;
                    r_k     <= pred_fix + 1'b1;
                    r_state <= ST_ERD;
                end
                ST_ERD: r_state <= ST_EWR;
                ST_EWR: begin
                    if (out_free) begin
                        r_out.task_id      <= seq_q;
                        r_out.route_number <= r_rn;
                        r_out.route_end    <= (r_k == r_cur);
                        r_out.last         <= (r_k == r_cur) && (r_p == '0);
                        r_out.infeasible   <= r_inf;
                        r_out.total_cost   <= r_total;
                        if (r_k == r_cur) begin
                            r_cur   <= r_p;
                            r_rn    <= r_rn + 6'd1;
                            r_state <= (r_p == '0) ? ST_IDLE : ST_BT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_ERD;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        r_out.task_id      <= '0;
                        r_out.route_number <= '0;
                        r_out.route_end    <= 1'b1;
                        r_out.last         <= 1'b1;
                        r_out.infeasible   <= 1'b0;
                        r_out.total_cost   <= '0;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `RSW_ASSERT_IMP(a_dp_write_phase, dp_we, (r_state == ST_INIT) || (r_state == ST_CALC), "best-cost write outside init or step")
    `RSW_ASSERT_IMP(a_step_bounds, r_state == ST_CALC, (r_j >= r_i) && (r_j <= r_n) && (r_i != '0), "extension position out of range")
    `RSW_ASSERT_IMP(a_emit_bounds, r_state == ST_EWR, (r_k > r_p) && (r_k <= r_cur) && (r_cur <= r_n), "emitted position outside route")
    `RSW_ASSERT_NXT(a_last_idle, (r_state == ST_EWR) && out_free && (r_k == r_cur) && (r_p == '0), r_state == ST_IDLE, "run did not finish after last transfer")
endmodule
